### rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator core.
// Holds the block table entry format, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	localparam int HEAP_BYTES   = 1024;
	localparam int HEADER_BYTES = 24;
	localparam int MAX_BLOCKS   = 64;

	localparam int IDX_W = 6;   // table index
	localparam int CNT_W = 7;   // block count, holds MAX_BLOCKS itself
	localparam int SZ_W  = 11;  // payload size
	localparam int OFF_W = 12;  // byte offset with headroom past the heap end
	localparam int REQ_W = 10;
	localparam int ADR_W = 10;

	localparam logic [SZ_W-1:0]  HDR_SZ   = SZ_W'(HEADER_BYTES);
	localparam logic [OFF_W-1:0] HDR_OFF  = OFF_W'(HEADER_BYTES);
	localparam logic [SZ_W-1:0]  HEAP_SZ  = SZ_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REALLOC = 2'd2,
		OP_STATS   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADADDR = 2'd2
	} status_t;

	typedef struct packed {
		logic            is_free;
		logic [SZ_W-1:0] size;
	} ent_t;

	localparam ent_t RESET_ENT = '{is_free: 1'b1, size: HEAP_SZ};

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		ent_t             data;
	} wr_t;

endpackage

`default_nettype wire

### rtl/core/first_fit_heap_allocator_core.sv
// First-fit heap allocator core: request decode, table walk sequencer, result register.
// Depends on ffha_pkg and ffha_table.
//
//  channel | dir | tuser              | tdata (lowest bit first)
//  s_*     | in  | [1:0] operation    | [9:0] request_size, [19:10] data_address, pad to 24
//  m_*     | out | [1:0] status       | [9:0] result_address, [20:10] used_bytes,
//          |     |                    | [31:21] free_bytes, [42:32] max_free,
//          |     |                    | [49:43] block_total, [56:50] free_block_count, pad 64
//
// Table reads are registered, so each entry visited takes a read state and a check state.
// Allocate scans entries, and on a split moves entries up and writes both halves.
// Free scans entries, frees the block, and on a merge moves entries down. Stats visits
// every block. The core passes back through idle before the next request is taken.
// Worst case is a reallocate. No clearing pass after reset.
// A finished result waits in the output register; a new request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_core
	import ffha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // request_size, data_address
	input  wire logic [1:0]  s_tuser,   // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // result_address, used, free, largest, total, nfree
	output logic [1:0]       m_tuser    // status
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_ARD   = 16'h0002,
		S_ACHK  = 16'h0004,
		S_INSRD = 16'h0008,
		S_INSWR = 16'h0010,
		S_SPHI  = 16'h0020,
		S_SPLO  = 16'h0040,
		S_FRD   = 16'h0080,
		S_FCHK  = 16'h0100,
		S_RRD   = 16'h0200,
		S_RCHK  = 16'h0400,
		S_DELRD = 16'h0800,
		S_DELWR = 16'h1000,
		S_SRD   = 16'h2000,
		S_SCHK  = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [REQ_W-1:0] req_q, req_d;
	logic [ADR_W-1:0] addr_q, addr_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] j_q, j_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [SZ_W-1:0]  sz_q, sz_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [ADR_W-1:0] nres_q, nres_d;
	logic             second_q, second_d;
	status_t          status_q, status_d;
	logic [ADR_W-1:0] res_q, res_d;
	logic [SZ_W-1:0]  used_q, used_d;
	logic [SZ_W-1:0]  fre_q, fre_d;
	logic [SZ_W-1:0]  lrg_q, lrg_d;
	logic [CNT_W-1:0] tot_q, tot_d;
	logic [CNT_W-1:0] nfr_q, nfr_d;

	logic             ovld_q;
	logic [63:0]      odata_q;
	logic [1:0]       ouser_q;
	logic             out_load;

	wr_t              wr;
	logic [IDX_W-1:0] raddr;
	ent_t             rdata;

	logic [CNT_W-1:0] idx_p1;
	logic [CNT_W-1:0] idx_p2;
	logic [CNT_W-1:0] j_p1;
	logic             last;
	logic [OFF_W-1:0] off_next;
	logic [OFF_W-1:0] split_min;

	ffha_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	assign idx_p1    = {1'b0, idx_q} + CNT_W'(1);
	assign idx_p2    = {1'b0, idx_q} + CNT_W'(2);
	assign j_p1      = {1'b0, j_q} + CNT_W'(1);
	assign last      = (idx_p1 >= cnt_q);
	assign off_next  = off_q + HDR_OFF + {1'b0, rdata.size};
	assign split_min = {2'b00, req_q} + HDR_OFF + OFF_W'(1);

	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!ovld_q || m_tready);

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		req_d    = req_q;
		addr_d   = addr_q;
		idx_d    = idx_q;
		j_d      = j_q;
		off_d    = off_q;
		sz_d     = sz_q;
		cnt_d    = cnt_q;
		nres_d   = nres_q;
		second_d = second_q;
		status_d = status_q;
		res_d    = res_q;
		used_d   = used_q;
		fre_d    = fre_q;
		lrg_d    = lrg_q;
		tot_d    = tot_q;
		nfr_d    = nfr_q;
		wr       = '0;
		raddr    = idx_q;

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_d     = op_t'(s_tuser);
					req_d    = s_tdata[9:0];
					addr_d   = s_tdata[19:10];
					idx_d    = '0;
					off_d    = HDR_OFF;
					second_d = 1'b0;
					status_d = ST_OK;
					res_d    = '0;
					used_d   = '0;
					fre_d    = '0;
					lrg_d    = '0;
					tot_d    = '0;
					nfr_d    = '0;
					case (op_t'(s_tuser))
						OP_ALLOC:   state_d = S_ARD;
						OP_FREE:    state_d = (s_tdata[19:10] == '0) ? S_DONE : S_FRD;
						OP_REALLOC: state_d = (s_tdata[19:10] == '0) ? S_ARD : S_FRD;
						default:    state_d = S_SRD;
					endcase
				end
			end
			S_ARD: begin
				state_d = S_ACHK;
			end
			S_ACHK: begin
				if (rdata.is_free && rdata.size >= {1'b0, req_q}) begin
					sz_d = rdata.size;
					if ({1'b0, rdata.size} >= split_min && cnt_q < MAX_CNT) begin
						if (idx_p1 < cnt_q) begin
							j_d     = IDX_W'(cnt_q - CNT_W'(1));
							state_d = S_INSRD;
						end else begin
							state_d = S_SPHI;
						end
					end else begin
						// hand out the whole block
						wr.en   = 1'b1;
						wr.addr = idx_q;
						wr.data = '{is_free: 1'b0, size: rdata.size};
						if (op_q == OP_REALLOC && addr_q != '0) begin
							nres_d   = off_q[ADR_W-1:0];
							second_d = 1'b1;
							idx_d    = '0;
							off_d    = HDR_OFF;
							state_d  = S_FRD;
						end else begin
							res_d   = off_q[ADR_W-1:0];
							state_d = S_DONE;
						end
					end
				end else if (last) begin
					status_d = ST_NOFIT;
					state_d  = S_DONE;
				end else begin
					idx_d   = IDX_W'(idx_p1);
					off_d   = off_next;
					state_d = S_ARD;
				end
			end
			S_INSRD: begin
				raddr   = j_q;
				state_d = S_INSWR;
			end
			S_INSWR: begin
				// move entry up one slot to open a hole after the split block
				wr.en   = 1'b1;
				wr.addr = IDX_W'(j_p1);
				wr.data = rdata;
				if (j_q == IDX_W'(idx_p1)) begin
					state_d = S_SPHI;
				end else begin
					j_d     = j_q - IDX_W'(1);
					state_d = S_INSRD;
				end
			end
			S_SPHI: begin
				wr.en   = 1'b1;
				wr.addr = IDX_W'(idx_p1);
				wr.data = '{is_free: 1'b1, size: sz_q - {1'b0, req_q} - HDR_SZ};
				state_d = S_SPLO;
			end
			S_SPLO: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = '{is_free: 1'b0, size: {1'b0, req_q}};
				cnt_d   = cnt_q + CNT_W'(1);
				if (op_q == OP_REALLOC && addr_q != '0) begin
					nres_d   = off_q[ADR_W-1:0];
					second_d = 1'b1;
					idx_d    = '0;
					off_d    = HDR_OFF;
					state_d  = S_FRD;
				end else begin
					res_d   = off_q[ADR_W-1:0];
					state_d = S_DONE;
				end
			end
			S_FRD: begin
				state_d = S_FCHK;
			end
			S_FCHK: begin
				if (off_q == {2'b00, addr_q} && !rdata.is_free) begin
					sz_d = rdata.size;
					if (op_q == OP_REALLOC && !second_q) begin
						if (rdata.size >= {1'b0, req_q}) begin
							res_d   = addr_q;
							state_d = S_DONE;
						end else begin
							idx_d   = '0;
							off_d   = HDR_OFF;
							state_d = S_ARD;
						end
					end else begin
						state_d = S_RRD;
					end
				end else if (last) begin
					status_d = ST_BADADDR;
					state_d  = S_DONE;
				end else begin
					idx_d   = IDX_W'(idx_p1);
					off_d   = off_next;
					state_d = S_FRD;
				end
			end
			S_RRD: begin
				raddr   = IDX_W'(idx_p1);
				state_d = S_RCHK;
			end
			S_RCHK: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				if (idx_p1 < cnt_q && rdata.is_free) begin
					// merge with the next block, then close the gap
					wr.data = '{is_free: 1'b1, size: sz_q + HDR_SZ + rdata.size};
					if (idx_p2 < cnt_q) begin
						j_d     = IDX_W'(idx_p2);
						state_d = S_DELRD;
					end else begin
						cnt_d   = cnt_q - CNT_W'(1);
						res_d   = second_q ? nres_q : '0;
						state_d = S_DONE;
					end
				end else begin
					wr.data = '{is_free: 1'b1, size: sz_q};
					res_d   = second_q ? nres_q : '0;
					state_d = S_DONE;
				end
			end
			S_DELRD: begin
				raddr   = j_q;
				state_d = S_DELWR;
			end
			S_DELWR: begin
				wr.en   = 1'b1;
				wr.addr = j_q - IDX_W'(1);
				wr.data = rdata;
				if (j_p1 < cnt_q) begin
					j_d     = IDX_W'(j_p1);
					state_d = S_DELRD;
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					res_d   = second_q ? nres_q : '0;
					state_d = S_DONE;
				end
			end
			S_SRD: begin
				state_d = S_SCHK;
			end
			S_SCHK: begin
				tot_d = tot_q + CNT_W'(1);
				if (rdata.is_free) begin
					nfr_d = nfr_q + CNT_W'(1);
					fre_d = fre_q + rdata.size;
					if (rdata.size > lrg_q) begin
						lrg_d = rdata.size;
					end
				end else begin
					used_d = used_q + rdata.size;
				end
				if (last) begin
					state_d = S_DONE;
				end else begin
					idx_d   = IDX_W'(idx_p1);
					state_d = S_SRD;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= CNT_W'(1);
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		req_q    <= req_d;
		addr_q   <= addr_d;
		idx_q    <= idx_d;
		j_q      <= j_d;
		off_q    <= off_d;
		sz_q     <= sz_d;
		nres_q   <= nres_d;
		second_q <= second_d;
		status_q <= status_d;
		res_q    <= res_d;
		used_q   <= used_d;
		fre_q    <= fre_d;
		lrg_q    <= lrg_d;
		tot_q    <= tot_d;
		nfr_q    <= nfr_d;
		if (out_load) begin
			odata_q <= {7'b0, nfr_q, tot_q, lrg_q, fre_q, used_q, res_q};
			ouser_q <= status_q;
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

endmodule

`default_nettype wire

### rtl/core/ffha_table.sv
// Block table memory: one write port, one read port, registered read.
// Entry zero reads as the whole free heap until first written after reset.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffha_table
	import ffha_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wr_t              wr,
	input  wire logic [IDX_W-1:0] raddr,
	output ent_t                  rdata
);

	ent_t tbl_q [MAX_BLOCKS];
	ent_t rd_q;
	logic init_q;
	logic rd_init_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			tbl_q[wr.addr] <= wr.data;
		end
		rd_q <= tbl_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b1;
			rd_init_q <= 1'b0;
		end else begin
			rd_init_q <= init_q && (raddr == '0);
			if (wr.en && wr.addr == '0) begin
				init_q <= 1'b0;
			end
		end
	end

	assign rdata = rd_init_q ? RESET_ENT : rd_q;

endmodule

`default_nettype wire
